>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BPRM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define BPRM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> hw/rtl/bprm_pkg.sv
// ----------------------------------------------------------------------------
// bprm_pkg
// Shared types and constants of the peak and RMS level meter.
// ----------------------------------------------------------------------------
package bprm_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 24;

    // Configuration register reset values.
    localparam logic [3:0]  RST_CHANNELS  = 4'd2;
    localparam logic [15:0] RST_BLOCK_LEN = 16'd1600;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_CHANNELS  = 1'b0,
        REG_BLOCK_LEN = 1'b1
    } cfg_reg_t;

    // Fixed-point log2: 6 integer bits, 24 fraction bits.
    localparam int LOG_FRAC = 24;
    localparam int LOG_W    = 30;

    // 20*log10(2) and 10*log10(2) in Q.24.
    localparam logic [26:0] K_PEAK = 27'd101008905;
    localparam logic [26:0] K_RMS  = 27'd50504453;

    localparam logic [16:0] DB_FLOOR = 17'd40960;

    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DATA_W  = 40;

    // Status of the shared log2 unit.
    typedef struct packed {
        logic busy;
        logic done;
    } log_stat_t;

    // Status of the job queue.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> hw/rtl/bprm_queue.sv
// ----------------------------------------------------------------------------
// bprm_queue
// Short first-word-fall-through queue of per-channel report jobs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bprm_queue #(
    parameter int W     = 108,
    parameter int DEPTH = bprm_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [W-1:0]       wr_data,
    input  logic               pop,
    output logic [W-1:0]       rd_data,
    output bprm_pkg::q_stat_t  stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_data    = entry_reg[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `BPRM_ASSERT_IMP(a_no_push_full, push, !stat.full)
    `BPRM_ASSERT_IMP(a_no_pop_empty, pop, !stat.empty)
    `BPRM_ASSERT_NXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

>>> hw/rtl/bprm_log2.sv
// ----------------------------------------------------------------------------
// bprm_log2
// Iterative fixed-point log2: six normalizing steps, then 24 squarings.
// ----------------------------------------------------------------------------
module bprm_log2 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [63:0]                   x,
    output bprm_pkg::log_stat_t           stat,
    output logic [bprm_pkg::LOG_W-1:0]    result
);

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_NORM = 3'b010,
        L_SQR  = 3'b100
    } lstate_t;

    lstate_t     state_reg;
    logic [63:0] norm_reg;
    logic [5:0]  lz_reg;
    logic [30:0] m_reg;
    logic [23:0] frac_reg;
    logic [4:0]  step_reg;
    logic        done_reg;

    logic [63:0] norm_shift;
    logic [5:0]  lz_add;
    logic [61:0] sq;
    logic [31:0] sq_top;

    assign stat.busy = (state_reg != L_IDLE);
    assign stat.done = done_reg;
    assign result    = {6'd63 - lz_reg, frac_reg};

    // One binary step of the leading-zero search.
    always_comb
    begin
        norm_shift = norm_reg;
        lz_add     = 6'd0;
        unique case (step_reg)
            5'd0:
            begin
                if (norm_reg[63:32] == '0)
                begin
                    norm_shift = {norm_reg[31:0], 32'd0};
                    lz_add     = 6'd32;
                end
            end
            5'd1:
            begin
                if (norm_reg[63:48] == '0)
                begin
                    norm_shift = {norm_reg[47:0], 16'd0};
                    lz_add     = 6'd16;
                end
            end
            5'd2:
            begin
                if (norm_reg[63:56] == '0)
                begin
                    norm_shift = {norm_reg[55:0], 8'd0};
                    lz_add     = 6'd8;
                end
            end
            5'd3:
            begin
                if (norm_reg[63:60] == '0)
                begin
                    norm_shift = {norm_reg[59:0], 4'd0};
                    lz_add     = 6'd4;
                end
            end
            5'd4:
            begin
                if (norm_reg[63:62] == '0)
                begin
                    norm_shift = {norm_reg[61:0], 2'd0};
                    lz_add     = 6'd2;
                end
            end
            5'd5:
            begin
                if (!norm_reg[63])
                begin
                    norm_shift = {norm_reg[62:0], 1'b0};
                    lz_add     = 6'd1;
                end
            end
            default:
            begin
                norm_shift = norm_reg;
                lz_add     = 6'd0;
            end
        endcase
    end

    // Square the Q1.30 mantissa; each squaring yields one fraction bit.
    assign sq     = {31'd0, m_reg} * {31'd0, m_reg};
    assign sq_top = sq[61:30];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
            norm_reg  <= '0;
            lz_reg    <= '0;
            m_reg     <= '0;
            frac_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        norm_reg  <= x;
                        lz_reg    <= '0;
                        step_reg  <= '0;
                        state_reg <= L_NORM;
                    end
                end
                L_NORM:
                begin
                    norm_reg <= norm_shift;
                    lz_reg   <= lz_reg + lz_add;
                    if (step_reg == 5'd5)
                    begin
                        m_reg     <= norm_shift[63:33];
                        frac_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= L_SQR;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                L_SQR:
                begin
                    if (sq_top[31])
                    begin
                        m_reg    <= sq_top[31:1];
                        frac_reg <= {frac_reg[22:0], 1'b1};
                    end
                    else
                    begin
                        m_reg    <= sq_top[30:0];
                        frac_reg <= {frac_reg[22:0], 1'b0};
                    end
                    if (step_reg == 5'(bprm_pkg::LOG_FRAC - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= L_IDLE;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/bprm_front.sv
// ----------------------------------------------------------------------------
// bprm_front
// Takes samples, keeps per-channel peak and square sum, counts frames and
// queues one report job per channel at the end of each block.
// ----------------------------------------------------------------------------
module bprm_front #(
    parameter int MAX_CHANNELS = bprm_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = bprm_pkg::SAMPLE_BITS_DEF,
    localparam int JOB_W       = 84 + SAMPLE_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [0:0]              cfg_addr,
    input  logic [15:0]             cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [2:0]              channel,
    input  logic [SAMPLE_BITS-1:0]  sample,
    output logic                    push,
    output logic [JOB_W-1:0]        job,
    input  bprm_pkg::q_stat_t       q_stat
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_SQ   = 4'b0010,
        F_ACC  = 4'b0100,
        F_EMIT = 4'b1000
    } fstate_t;

    fstate_t                  state_reg;
    logic [3:0]               chan_cfg_reg;
    logic [15:0]              len_cfg_reg;
    logic [15:0]              frame_reg;
    logic [2:0]               ch_reg;
    logic [SAMPLE_BITS-1:0]   mag_reg;
    logic [2*SAMPLE_BITS-1:0] sq_reg;
    logic [SAMPLE_BITS-1:0]   peak_reg [MAX_CHANNELS];
    logic [63:0]              sum_reg  [MAX_CHANNELS];

    logic [3:0]               n_eff;
    logic [15:0]              len_eff;
    logic [IDX_W-1:0]         idx;
    logic                     ch_last;
    logic [15:0]              frame_inc;
    logic [64:0]              sum_add;
    logic [SAMPLE_BITS-1:0]   mag_in;
    logic                     accept;

    // Effective channel count and block length.
    always_comb
    begin
        if (chan_cfg_reg == 4'd0)
        begin
            n_eff = 4'd1;
        end
        else if (chan_cfg_reg > 4'(MAX_CHANNELS))
        begin
            n_eff = 4'(MAX_CHANNELS);
        end
        else
        begin
            n_eff = chan_cfg_reg;
        end
    end

    assign len_eff   = (len_cfg_reg == 16'd0) ? 16'd1 : len_cfg_reg;
    assign idx       = ch_reg[IDX_W-1:0];
    assign ch_last   = ({1'b0, ch_reg} == n_eff - 4'd1);
    assign frame_inc = frame_reg + 16'd1;
    assign sum_add   = {1'b0, sum_reg[idx]} + 65'(sq_reg);
    assign mag_in    = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

    assign s_tready = (state_reg == F_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign push     = (state_reg == F_EMIT) && !q_stat.full;
    assign job      = {len_eff, sum_reg[idx], peak_reg[idx], ch_last, ch_reg};

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_cfg_reg <= bprm_pkg::RST_CHANNELS;
            len_cfg_reg  <= bprm_pkg::RST_BLOCK_LEN;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == bprm_pkg::REG_CHANNELS)
            begin
                chan_cfg_reg <= cfg_wdata[3:0];
            end
            else
            begin
                len_cfg_reg <= cfg_wdata;
            end
        end
    end

    // Sample magnitude and its square.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg <= mag_in;
        end
        if (state_reg == F_SQ)
        begin
            sq_reg <= mag_reg * mag_reg;
        end
    end

    // Sequencer, frame count and accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            frame_reg <= '0;
            ch_reg    <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                peak_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept && ({1'b0, channel} < n_eff))
                    begin
                        ch_reg    <= channel;
                        state_reg <= F_SQ;
                    end
                end
                F_SQ:
                begin
                    state_reg <= F_ACC;
                end
                F_ACC:
                begin
                    if (mag_reg > peak_reg[idx])
                    begin
                        peak_reg[idx] <= mag_reg;
                    end
                    // Saturate the square sum at all ones.
                    sum_reg[idx] <= sum_add[64] ? '1 : sum_add[63:0];
                    if (ch_last && (frame_inc >= len_eff))
                    begin
                        ch_reg    <= '0;
                        state_reg <= F_EMIT;
                    end
                    else
                    begin
                        if (ch_last)
                        begin
                            frame_reg <= frame_inc;
                        end
                        state_reg <= F_IDLE;
                    end
                end
                F_EMIT:
                begin
                    if (push)
                    begin
                        if (ch_last)
                        begin
                            for (int i = 0; i < MAX_CHANNELS; i++)
                            begin
                                peak_reg[i] <= '0;
                                sum_reg[i]  <= '0;
                            end
                            frame_reg <= '0;
                            state_reg <= F_IDLE;
                        end
                        else
                        begin
                            ch_reg <= ch_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/bprm_back.sv
// ----------------------------------------------------------------------------
// bprm_back
// Turns queued per-channel jobs into peak and RMS levels in signed Q9.8 dB.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bprm_back #(
    parameter int SAMPLE_BITS = bprm_pkg::SAMPLE_BITS_DEF,
    localparam int JOB_W      = 84 + SAMPLE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [JOB_W-1:0]                   job,
    input  bprm_pkg::q_stat_t                  q_stat,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bprm_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [2:0]                         m_tuser,
    output logic                               m_tlast
);

    localparam logic [31:0] PEAK_REF = 32'(SAMPLE_BITS - 1) << bprm_pkg::LOG_FRAC;
    localparam logic [31:0] RMS_REF  = 32'(2 * (SAMPLE_BITS - 1)) << bprm_pkg::LOG_FRAC;
    localparam logic [16:0] DB_MIN   = 17'd0 - bprm_pkg::DB_FLOOR;

    typedef enum logic [8:0] {
        B_IDLE = 9'b000000001,
        B_LOGP = 9'b000000010,
        B_LOGS = 9'b000000100,
        B_LOGL = 9'b000001000,
        B_MULP = 9'b000010000,
        B_RNDP = 9'b000100000,
        B_MULR = 9'b001000000,
        B_RNDR = 9'b010000000,
        B_OUT  = 9'b100000000
    } bstate_t;

    bstate_t                       state_reg;
    logic                          start_reg;
    logic [2:0]                    ch_reg;
    logic                          last_reg;
    logic [SAMPLE_BITS-1:0]        peak_reg;
    logic [63:0]                   sum_reg;
    logic [15:0]                   len_reg;
    logic [bprm_pkg::LOG_W-1:0]    logp_reg;
    logic [bprm_pkg::LOG_W-1:0]    logs_reg;
    logic [bprm_pkg::LOG_W-1:0]    logl_reg;
    logic [57:0]                   prod_reg;
    logic [16:0]                   peak_db_reg;
    logic [16:0]                   rms_db_reg;

    logic [63:0]                   log_x;
    bprm_pkg::log_stat_t           log_stat;
    logic [bprm_pkg::LOG_W-1:0]    log_res;
    logic [31:0]                   d_peak;
    logic [31:0]                   d_rms;
    logic [31:0]                   d_sel;
    logic                          zero_sel;
    logic [57:0]                   prod_rnd;
    logic [17:0]                   q;
    logic [16:0]                   q_sat;
    logic [16:0]                   db_code;

    assign pop = (state_reg == B_IDLE) && !q_stat.empty;

    // Operand of the shared log2 unit.
    always_comb
    begin
        unique case (state_reg)
            B_LOGP:  log_x = 64'(peak_reg);
            B_LOGS:  log_x = sum_reg;
            default: log_x = 64'(len_reg);
        endcase
    end

    bprm_log2 u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .x      (log_x),
        .stat   (log_stat),
        .result (log_res)
    );

    // Negated log ratios in Q.24.
    assign d_peak = PEAK_REF - 32'(logp_reg);
    assign d_rms  = RMS_REF + 32'(logl_reg) - 32'(logs_reg);
    assign d_sel  = (state_reg == B_MULR || state_reg == B_RNDR) ? d_rms : d_peak;
    assign zero_sel = (state_reg == B_RNDR) ? (sum_reg == '0) : (peak_reg == '0);

    // Round half up by 40 bits, saturate at the floor, negate.
    assign prod_rnd = prod_reg + (58'd1 << 39);
    assign q        = prod_rnd[57:40];
    assign q_sat    = (q > 18'(bprm_pkg::DB_FLOOR)) ? bprm_pkg::DB_FLOOR : q[16:0];

    always_comb
    begin
        if (zero_sel)
        begin
            db_code = DB_MIN;
        end
        else if (d_sel[31] || d_sel == '0)
        begin
            db_code = '0;
        end
        else
        begin
            db_code = 17'd0 - q_sat;
        end
    end

    assign m_tvalid = (state_reg == B_OUT);
    assign m_tdata  = {6'd0, rms_db_reg, peak_db_reg};
    assign m_tuser  = ch_reg;
    assign m_tlast  = last_reg;

    // Job payload and arithmetic results.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ch_reg   <= job[2:0];
            last_reg <= job[3];
            peak_reg <= job[4 +: SAMPLE_BITS];
            sum_reg  <= job[4 + SAMPLE_BITS +: 64];
            len_reg  <= job[68 + SAMPLE_BITS +: 16];
        end
        if (log_stat.done)
        begin
            if (state_reg == B_LOGP)
            begin
                logp_reg <= log_res;
            end
            if (state_reg == B_LOGS)
            begin
                logs_reg <= log_res;
            end
            if (state_reg == B_LOGL)
            begin
                logl_reg <= log_res;
            end
        end
        if (state_reg == B_MULP)
        begin
            prod_reg <= {27'd0, d_sel[30:0]} * {31'd0, bprm_pkg::K_PEAK};
        end
        if (state_reg == B_MULR)
        begin
            prod_reg <= {27'd0, d_sel[30:0]} * {31'd0, bprm_pkg::K_RMS};
        end
        if (state_reg == B_RNDP)
        begin
            peak_db_reg <= db_code;
        end
        if (state_reg == B_RNDR)
        begin
            rms_db_reg <= db_code;
        end
    end

    // Job sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        start_reg <= 1'b1;
                        state_reg <= B_LOGP;
                    end
                end
                B_LOGP:
                begin
                    if (log_stat.done)
                    begin
                        start_reg <= 1'b1;
                        state_reg <= B_LOGS;
                    end
                end
                B_LOGS:
                begin
                    if (log_stat.done)
                    begin
                        start_reg <= 1'b1;
                        state_reg <= B_LOGL;
                    end
                end
                B_LOGL:
                begin
                    if (log_stat.done)
                    begin
                        state_reg <= B_MULP;
                    end
                end
                B_MULP: state_reg <= B_RNDP;
                B_RNDP: state_reg <= B_MULR;
                B_MULR: state_reg <= B_RNDR;
                B_RNDR: state_reg <= B_OUT;
                B_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    `BPRM_ASSERT_NXT(a_pop_starts_log, pop, state_reg == B_LOGP && start_reg)
    `BPRM_ASSERT_IMP(a_done_in_log, log_stat.done,
        state_reg == B_LOGP || state_reg == B_LOGS || state_reg == B_LOGL)
    `BPRM_ASSERT_IMP(a_levels_not_positive, m_tvalid,
        (peak_db_reg[16] || peak_db_reg == '0) && (rms_db_reg[16] || rms_db_reg == '0))

endmodule

>>> hw/rtl/block_peak_rms_meter_top.sv
// Flow: a sample for a used channel is squared, then folded into its channel,
// before the next sample is taken; one sample per cycle for an unused channel.
// At block end one job per channel is queued, stalling while the queue is
// full; the back end takes one job at a time through three log2 runs.
// Reset clears accumulators and frame count; channels 2, block length 1600.
// ----------------------------------------------------------------------------
// block_peak_rms_meter_top
// Multichannel peak and RMS level meter with signed Q9.8 dB results per block.
// ----------------------------------------------------------------------------
module block_peak_rms_meter_top #(
    parameter int MAX_CHANNELS = bprm_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = bprm_pkg::SAMPLE_BITS_DEF,
    localparam int IN_DATA_W   = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [0:0]                         cfg_addr,
    input  logic [15:0]                        cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [IN_DATA_W-1:0]               s_tdata,   // sample
    input  logic [2:0]                         s_tuser,   // channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bprm_pkg::OUT_DATA_W-1:0]    m_tdata,   // peak_db, rms_db
    output logic [2:0]                         m_tuser,   // out_channel
    output logic                               m_tlast
);

    localparam int JOB_W = 84 + SAMPLE_BITS;

    logic              push;
    logic              pop;
    logic [JOB_W-1:0]  wr_job;
    logic [JOB_W-1:0]  rd_job;
    bprm_pkg::q_stat_t q_stat;

    // Front end: accumulation and block framing.
    bprm_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .channel   (s_tuser),
        .sample    (s_tdata[SAMPLE_BITS-1:0]),
        .push      (push),
        .job       (wr_job),
        .q_stat    (q_stat)
    );

    // Job queue between the two halves.
    bprm_queue #(
        .W     (JOB_W),
        .DEPTH (bprm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_job),
        .pop     (pop),
        .rd_data (rd_job),
        .stat    (q_stat)
    );

    // Back end: level computation and result output.
    bprm_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (rd_job),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> sim/block_peak_rms_meter_top_test.sv
// ----------------------------------------------------------------------------
// block_peak_rms_meter_top_test
// Streams interleaved samples into the level meter and checks every report.
// An in-bench model of the per-channel peak and square-sum accumulators
// predicts each report. The run has directed extremes first, then random
// phases with several channel counts and block lengths, and random stalls
// on both streams.
// ----------------------------------------------------------------------------
module block_peak_rms_meter_top_test;

    // One per-channel level report.
    typedef struct packed {
        logic [2:0]  chan;
        logic [16:0] peak;
        logic [16:0] rms;
        logic        last;
    } level_rpt_t;

    // Level meter model and the queue of reports it predicts.
    class level_scoreboard;
        logic [3:0]  chans_reg;
        logic [15:0] blen_reg;
        logic [63:0] peak_mag [8];
        logic [63:0] sq_sum [8];
        logic [15:0] frames;
        level_rpt_t  expected_rpts[$];
        int          errors;

        function new();
            chans_reg = bprm_pkg::RST_CHANNELS;
            blen_reg  = bprm_pkg::RST_BLOCK_LEN;
            frames    = '0;
            errors    = 0;
            foreach (peak_mag[i])
            begin
                peak_mag[i] = '0;
                sq_sum[i]   = '0;
            end
        endfunction

        function void write_reg(bprm_pkg::cfg_reg_t idx, logic [15:0] val);
            if (idx == bprm_pkg::REG_CHANNELS)
                chans_reg = val[3:0];
            else
                blen_reg = val;
        endfunction

        // Log2 in Q.24 by repeated squaring of the normalized mantissa.
        function logic [63:0] log2_q24(logic [63:0] x);
            int          top;
            logic [63:0] m;
            logic [63:0] frac;
            top  = 0;
            frac = '0;
            while (top < 63 && (x >> (top + 1)) != 0)
                top++;
            if (top >= 30)
                m = x >> (top - 30);
            else
                m = x << (30 - top);
            for (int i = 0; i < 24; i++)
            begin
                m    = (m * m) >> 30;
                frac = frac << 1;
                if (m >= 64'h8000_0000)
                begin
                    m       = m >> 1;
                    frac[0] = 1'b1;
                end
            end
            return (64'(top) << 24) | frac;
        endfunction

        // Attenuation in Q.24 to a non-positive signed Q9.8 dB code with floor.
        function logic [16:0] atten_to_db(longint d, logic [63:0] k);
            logic [63:0] q;
            if (d <= 0)
                return '0;
            q = (64'(d) * k + (64'd1 << 39)) >> 40;
            if (q > 64'(bprm_pkg::DB_FLOOR))
                q = 64'(bprm_pkg::DB_FLOOR);
            return 17'(64'd0 - q);
        endfunction

        function void note_sample(logic [2:0] ch, logic [23:0] raw);
            int          n;
            logic [63:0] mag;
            logic [63:0] sq;
            logic [63:0] len;
            longint      d;
            level_rpt_t  r;
            n = (chans_reg == 0) ? 1 : (chans_reg > 8) ? 8 : int'(chans_reg);
            if (int'(ch) >= n)
                return;
            mag = raw[23] ? (64'd1 << 24) - 64'(raw) : 64'(raw);
            if (mag > peak_mag[ch])
                peak_mag[ch] = mag;
            sq = mag * mag;
            if (sq_sum[ch] + sq < sq_sum[ch])
                sq_sum[ch] = '1;
            else
                sq_sum[ch] = sq_sum[ch] + sq;
            if (int'(ch) != n - 1)
                return;
            frames = frames + 16'd1;
            len    = (blen_reg == 0) ? 64'd1 : 64'(blen_reg);
            if (64'(frames) < len)
                return;
            for (int c = 0; c < n; c++)
            begin
                r.chan = 3'(c);
                if (peak_mag[c] == 0)
                    r.peak = 17'(-bprm_pkg::DB_FLOOR);
                else
                begin
                    d = (longint'(23) << 24) - longint'(log2_q24(peak_mag[c]));
                    r.peak = atten_to_db(d, 64'(bprm_pkg::K_PEAK));
                end
                if (sq_sum[c] == 0)
                    r.rms = 17'(-bprm_pkg::DB_FLOOR);
                else
                begin
                    d = (longint'(46) << 24) + longint'(log2_q24(len))
                        - longint'(log2_q24(sq_sum[c]));
                    r.rms = atten_to_db(d, 64'(bprm_pkg::K_RMS));
                end
                r.last = (c == n - 1);
                expected_rpts.push_back(r);
            end
            foreach (peak_mag[i])
            begin
                peak_mag[i] = '0;
                sq_sum[i]   = '0;
            end
            frames = '0;
        endfunction

        function void check_report(level_rpt_t got);
            level_rpt_t want;
            if (expected_rpts.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected report: chan %0d peak %0d rms %0d last %0d",
                             got.chan, $signed(got.peak), $signed(got.rms), got.last);
                return;
            end
            want = expected_rpts.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("Report mismatch: expected chan %0d peak %0d rms %0d last %0d",
                             want.chan, $signed(want.peak), $signed(want.rms), want.last);
                    $display("                 got      chan %0d peak %0d rms %0d last %0d",
                             got.chan, $signed(got.peak), $signed(got.rms), got.last);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    level_scoreboard sb = new();
    int  sink_hold;
    bit  sink_fast;
    bit  src_fast;
    int  rand_items;

    block_peak_rms_meter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Clock with a 12-unit period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Result side: random per-transaction stalls and one long hold-off.
    initial
    begin
        int stall;
        stall     = 0;
        sink_hold = 0;
        sink_fast = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                sb.check_report({m_tuser, m_tdata[16:0], m_tdata[33:17], m_tlast});
                stall = sink_fast ? 0 : $urandom_range(0, 18);
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                m_tready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Run limit.
    initial
    begin
        #(12 * 600000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offers one sample and waits for its transaction, then idles a while.
    task automatic send_sample(logic [2:0] ch, logic [23:0] smp);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= ch;
        s_tdata  <= smp;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample(ch, smp);
        rand_items++;
        gap = src_fast ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Waits until every report has come and the block has settled.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_rpts.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(bprm_pkg::cfg_reg_t idx, logic [15:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'h000000;
            3: return 24'(int'($urandom_range(0, 64)) - 32);
            4: return 24'($urandom_range(0, 255)) << $urandom_range(0, 16);
            default: return 24'($urandom());
        endcase
    endfunction

    // One random phase: new settings, then mostly whole frames.
    task automatic random_phase();
        int          n;
        int          nframes;
        logic [3:0]  creg;
        logic [15:0] blen;
        creg = $urandom_range(0, 9) == 0 ? ($urandom_range(0, 1) ? 4'd0 : 4'd15)
                                         : 4'($urandom_range(1, 8));
        blen = $urandom_range(0, 5) == 0 ? 16'($urandom_range(0, 12))
                                         : 16'($urandom_range(1, 4));
        write_reg(bprm_pkg::REG_CHANNELS, 16'(creg) | (16'($urandom()) & 16'hFFF0));
        write_reg(bprm_pkg::REG_BLOCK_LEN, blen);
        n = (creg == 0) ? 1 : (creg > 8) ? 8 : int'(creg);
        src_fast  = $urandom_range(0, 3) == 0;
        sink_fast = $urandom_range(0, 3) == 0;
        nframes   = ((blen == 0) ? 1 : int'(blen)) * $urandom_range(1, 3);
        for (int f = 0; f < nframes; f++)
        begin
            if (rand_items >= 260)
                break;
            if ($urandom_range(0, 6) == 0)
            begin
                // Noise: any channel, possibly unused or out of order.
                logic [2:0] ch;
                ch = 3'($urandom_range(0, 7));
                send_sample(ch, pick_sample());
            end
            for (int c = 0; c < n; c++)
            begin
                send_sample(3'(c), pick_sample());
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = bprm_pkg::REG_CHANNELS;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        rand_items = 0;
        src_fast   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default settings: extremes, zero and an unused channel.
        send_sample(3'd0, 24'h800000);
        send_sample(3'd1, 24'h7FFFFF);
        send_sample(3'd5, 24'h123456);
        send_sample(3'd0, 24'hFFFFFF);
        send_sample(3'd1, 24'h000000);
        // Block length lowered below the frame count: emits on next frame.
        write_reg(bprm_pkg::REG_BLOCK_LEN, 16'd1);
        send_sample(3'd0, 24'h000001);
        send_sample(3'd1, 24'h000000);
        // Channels above the maximum, longest block, then shortened.
        write_reg(bprm_pkg::REG_CHANNELS, 16'd15);
        write_reg(bprm_pkg::REG_BLOCK_LEN, 16'd65535);
        for (int c = 0; c < 8; c++)
            send_sample(3'(c), (c % 2) ? 24'h800000 : 24'h000000);
        write_reg(bprm_pkg::REG_BLOCK_LEN, 16'd0);
        for (int c = 0; c < 8; c++)
            send_sample(3'(c), 24'(c * 1000 + 1));
        // Zero channels act as one; a full-scale single sample block.
        write_reg(bprm_pkg::REG_CHANNELS, 16'd0);
        send_sample(3'd0, 24'h7FFFFF);
        send_sample(3'd3, 24'h800000);
        send_sample(3'd0, 24'h800001);

        // Long hold-off on the result side while samples keep coming.
        write_reg(bprm_pkg::REG_CHANNELS, 16'd8);
        write_reg(bprm_pkg::REG_BLOCK_LEN, 16'd1);
        sink_hold = 3000;
        src_fast  = 1'b1;
        for (int f = 0; f < 6; f++)
            for (int c = 0; c < 8; c++)
                send_sample(3'(c), pick_sample());
        src_fast = 1'b0;

        while (rand_items < 260)
            random_phase();

        drain();
        if (sb.errors == 0 && sb.expected_rpts.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> block_peak_rms_meter_top.f
+incdir+hw/rtl
hw/rtl/bprm_pkg.sv
hw/rtl/bprm_queue.sv
hw/rtl/bprm_log2.sv
hw/rtl/bprm_front.sv
hw/rtl/bprm_back.sv
hw/rtl/block_peak_rms_meter_top.sv
sim/block_peak_rms_meter_top_test.sv
